FILE: rtl/ucb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucb_pkg: shared types and constants of the UCB1 child selector
// Beat structs, fixed-point widths and the ln 2 constant.
// ----------------------------------------------------------------------------
package ucb_pkg;

    localparam int unsigned IDX_W        = 6;
    localparam int unsigned CNT_W        = 24;
    localparam int unsigned SUM_W        = 32;
    localparam int unsigned SCORE_W      = 48;
    localparam int unsigned C_W          = 16;
    localparam int unsigned MAX_CHILDREN = 64;
    localparam logic [C_W-1:0] C_RESET   = 16'd362;
    localparam logic [15:0]    LN2_Q16   = 16'd45426;

    typedef struct packed {
        logic [IDX_W-1:0]        child_index;
        logic                    child_valid;
        logic [CNT_W-1:0]        child_visits;
        logic signed [SUM_W-1:0] child_score_sum;
        logic [CNT_W-1:0]        parent_visits;
        logic                    player_side;
        logic                    last_child;
    } child_beat_t;

    typedef struct packed {
        logic [IDX_W-1:0] selected_child;
        logic             no_legal_child;
    } choice_beat_t;

    // Operation codes of the shared arithmetic unit
    typedef enum logic [1:0] {
        OP_DIV  = 2'd0,
        OP_MUL  = 2'd1,
        OP_SQRT = 2'd2
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

endpackage : ucb_pkg
`default_nettype wire

FILE: rtl/ucb_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucb_alu: shared iterative arithmetic unit
// Restoring divide (64/32), shift-add multiply (64x32) and integer square
// root (64 bit), one bit (or one bit pair) per cycle, through one adder/subtractor.
// ----------------------------------------------------------------------------
module ucb_alu (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ucb_pkg::alu_ctrl_t  ctrl,
    input  wire logic [63:0]         op_a,
    input  wire logic [31:0]         op_b,
    output logic                     done,
    output logic [63:0]              result
);

    logic [63:0] acc_reg, acc_next;     // quotient / product / root
    logic [64:0] rem_reg, rem_next;     // remainder / sqrt residue
    logic [63:0] src_reg, src_next;     // shifted-out dividend / radicand
    logic [31:0] b_reg, b_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    ucb_pkg::alu_op_t op_reg, op_next;

    logic [64:0] trial;
    logic [64:0] rem_sh;
    logic [64:0] sub_b;

    // Form the shifted remainder and the subtrahend of this step
    always_comb
    begin
        rem_sh = '0;
        sub_b  = '0;
        case (op_reg)
            ucb_pkg::OP_DIV:
            begin
                rem_sh = {rem_reg[63:0], src_reg[63]};
                sub_b  = {33'd0, b_reg};
            end
            ucb_pkg::OP_SQRT:
            begin
                rem_sh = {rem_reg[62:0], src_reg[63:62]};
                sub_b  = {acc_reg[62:0], 2'b01};
            end
            ucb_pkg::OP_MUL:
            begin
                rem_sh = {1'b0, acc_reg};
                sub_b  = {33'd0, b_reg};
            end
            default:
            begin
                rem_sh = '0;
                sub_b  = '0;
            end
        endcase
    end

    assign trial = (op_reg == ucb_pkg::OP_MUL) ? (rem_sh + sub_b) : (rem_sh - sub_b);

    // Advance one step per cycle
    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        src_next  = src_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        op_next   = op_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            op_next   = ctrl.op;
            b_next    = op_b;
            rem_next  = '0;
            acc_next  = '0;
            src_next  = op_a;
            busy_next = 1'b1;
            cnt_next  = (ctrl.op == ucb_pkg::OP_SQRT) ? 7'd32 : 7'd64;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                ucb_pkg::OP_MUL:
                begin
                    // acc holds high part; src shifts multiplier out LSB first
                    if (src_reg[0])
                        acc_next = trial[64:1];
                    else
                        acc_next = {1'b0, acc_reg[63:1]};
                    rem_next = {rem_reg[63:0], 1'b0};
                    src_next = {(src_reg[0] ? trial[0] : acc_reg[0]), src_reg[63:1]};
                end
                ucb_pkg::OP_DIV:
                begin
                    src_next = {src_reg[62:0], 1'b0};
                    if (!trial[64])
                    begin
                        rem_next = trial;
                        acc_next = {acc_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        acc_next = {acc_reg[62:0], 1'b0};
                    end
                end
                ucb_pkg::OP_SQRT:
                begin
                    src_next = {src_reg[61:0], 2'b00};
                    if (!trial[64])
                    begin
                        rem_next = trial;
                        acc_next = {acc_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        acc_next = {acc_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= ucb_pkg::OP_DIV;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        src_reg <= src_next;
        b_reg   <= b_next;
    end

    // Multiply: low product word sits in src, high word in acc
    assign done   = done_reg;
    assign result = (op_reg == ucb_pkg::OP_MUL) ? src_reg : acc_reg;

endmodule : ucb_alu
`default_nettype wire

FILE: rtl/ucb1_child_selector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ucb1_child_selector: UCB1 child selection for a tree search step
//
// Children arrive one beat each on the in channel (in_valid / in_stall); the
// beat with last_child set closes a selection and one choice beat leaves on
// the out channel (out_valid / out_stall). The first legal unvisited child
// wins; otherwise the legal child with the highest saturated Q32.16 UCB1
// score wins, earlier child on a tie. C is written on the cfg channel.
// A skipped or unvisited child needs no arithmetic. A scored child runs a
// divide, sixteen squarings, one multiply by ln 2, a second divide, a square
// root and a multiply by C, all on one shared bit-serial unit. The input
// stalls while an item is in work. A waiting choice beat sits in its output
// register; the next selection's children are still taken, but its last
// child waits at the input until the choice beat has left.
// Reset clears the selection and sets C to 362.
// ----------------------------------------------------------------------------
module ucb1_child_selector (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire ucb_pkg::child_beat_t   in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output ucb_pkg::choice_beat_t       out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [15:0]            cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MEAN, S_LOGSQ, S_LNMUL, S_DIV2, S_SQRT, S_BONUS, S_CMP, S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    ucb_pkg::child_beat_t item_reg;
    logic [15:0]         c_reg;
    logic [5:0]          best_child_reg, unv_child_reg;
    logic signed [47:0]  best_score_reg;
    logic                have_best_reg, unv_seen_reg;
    logic signed [48:0]  mean_reg;
    logic [4:0]          k_reg;
    logic [14:0]         frac_reg;
    logic [4:0]          it_reg;
    logic [47:0]         tmp_reg;
    logic                out_valid_reg;
    ucb_pkg::choice_beat_t out_data_reg;

    ucb_pkg::alu_ctrl_t  alu_ctrl;
    logic [63:0]         alu_a;
    logic [31:0]         alu_b;
    logic                alu_done;
    logic [63:0]         alu_res;

    logic                take;
    logic                part;
    logic [23:0]         np;
    logic [4:0]          lz_k;
    logic [31:0]         mag;
    logic signed [49:0]  score_w;
    logic signed [47:0]  score_sat;
    logic [63:0]         sq_sh;

    ucb_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (alu_ctrl),
        .op_a   (alu_a),
        .op_b   (alu_b),
        .done   (alu_done),
        .result (alu_res)
    );

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && in_data.last_child);
    assign take      = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign part = (item_reg.child_index != '0) && item_reg.child_valid;
    assign np   = (item_reg.parent_visits == '0) ? 24'd1 : item_reg.parent_visits;
    assign mag  = item_reg.child_score_sum[31] ? (32'd0 - item_reg.child_score_sum)
                                               : item_reg.child_score_sum;

    // Find the leading one of the parent count
    always_comb
    begin
        lz_k = '0;
        for (int i = 0; i < 24; i++)
        begin
            if (np[i])
                lz_k = 5'(i);
        end
    end

    assign sq_sh   = alu_res >> 30;
    assign score_w = item_reg.player_side ? (50'(signed'({1'b0, tmp_reg})) - 50'(mean_reg))
                                          : (50'(signed'({1'b0, tmp_reg})) + 50'(mean_reg));
    always_comb
    begin
        if (score_w > 50'sh7FFFFFFFFFFF)
            score_sat = 48'sh7FFFFFFFFFFF;
        else if (score_w < -50'sh800000000000)
            score_sat = -48'sh800000000000;
        else
            score_sat = score_w[47:0];
    end

    // Drive the shared unit
    always_comb
    begin
        alu_ctrl.start = 1'b0;
        alu_ctrl.op    = ucb_pkg::OP_DIV;
        alu_a          = '0;
        alu_b          = '0;
        state_next     = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (part && item_reg.child_visits != '0)
                begin
                    alu_ctrl.start = 1'b1;
                    alu_ctrl.op    = ucb_pkg::OP_DIV;
                    alu_a          = {32'd0, mag};
                    alu_b          = {8'd0, item_reg.child_visits};
                    state_next     = S_MEAN;
                end
                else
                    state_next = S_IDLE;
            end
            S_MEAN:
            begin
                if (alu_done)
                begin
                    alu_ctrl.start = 1'b1;
                    alu_ctrl.op    = ucb_pkg::OP_MUL;
                    alu_a          = 64'(np) << (5'd30 - lz_k);
                    alu_b          = 32'(64'(np) << (5'd30 - lz_k));
                    state_next     = S_LOGSQ;
                end
            end
            S_LOGSQ:
            begin
                if (alu_done)
                begin
                    alu_ctrl.start = 1'b1;
                    alu_ctrl.op    = ucb_pkg::OP_MUL;
                    if (it_reg == 5'd15)
                    begin
                        alu_a      = 64'({k_reg, frac_reg, (sq_sh >= 64'h80000000)});
                        alu_b      = {16'd0, ucb_pkg::LN2_Q16};
                        state_next = S_LNMUL;
                    end
                    else
                    begin
                        alu_a = (sq_sh >= 64'h80000000) ? (sq_sh >> 1) : sq_sh;
                        alu_b = 32'((sq_sh >= 64'h80000000) ? (sq_sh >> 1) : sq_sh);
                    end
                end
            end
            S_LNMUL:
            begin
                if (alu_done)
                begin
                    alu_ctrl.start = 1'b1;
                    alu_ctrl.op    = ucb_pkg::OP_DIV;
                    alu_a          = (alu_res >> 16) << 16;
                    alu_b          = {8'd0, item_reg.child_visits};
                    state_next     = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (alu_done)
                begin
                    alu_ctrl.start = 1'b1;
                    alu_ctrl.op    = ucb_pkg::OP_SQRT;
                    alu_a          = alu_res;
                    state_next     = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (alu_done)
                begin
                    alu_ctrl.start = 1'b1;
                    alu_ctrl.op    = ucb_pkg::OP_MUL;
                    alu_a          = alu_res;
                    alu_b          = {16'd0, c_reg};
                    state_next     = S_BONUS;
                end
            end
            S_BONUS:
            begin
                if (alu_done)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, selection and the choice beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            c_reg          <= ucb_pkg::C_RESET;
            best_child_reg <= '0;
            best_score_reg <= '0;
            have_best_reg  <= 1'b0;
            unv_seen_reg   <= 1'b0;
            unv_child_reg  <= '0;
            out_valid_reg  <= 1'b0;
            it_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                c_reg <= cfg_data;
            if (state_reg == S_MEAN)
                it_reg <= '0;
            if (state_reg == S_LOGSQ && alu_done)
                it_reg <= it_reg + 5'd1;
            // Close the selection on the last child
            if (state_next == S_IDLE && state_reg != S_IDLE && item_reg.last_child)
            begin
                out_valid_reg  <= 1'b1;
                unv_seen_reg   <= 1'b0;
                have_best_reg  <= 1'b0;
                best_child_reg <= '0;
                best_score_reg <= '0;
                unv_child_reg  <= '0;
            end
            else
            begin
                if (out_valid_reg && !out_stall)
                    out_valid_reg <= 1'b0;
                if (state_reg == S_EMIT && part && item_reg.child_visits == '0 &&
                    !unv_seen_reg)
                begin
                    unv_seen_reg  <= 1'b1;
                    unv_child_reg <= item_reg.child_index;
                end
                if (state_reg == S_CMP && (!have_best_reg || score_sat > best_score_reg))
                begin
                    have_best_reg  <= 1'b1;
                    best_score_reg <= score_sat;
                    best_child_reg <= item_reg.child_index;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= in_data;
        if (state_reg == S_MEAN && alu_done)
            mean_reg <= item_reg.child_score_sum[31] ? -49'(signed'({1'b0, alu_res[47:0]}))
                                                     : 49'(signed'({1'b0, alu_res[47:0]}));
        if (state_reg == S_MEAN)
        begin
            k_reg    <= lz_k;
            frac_reg <= '0;
        end
        if (state_reg == S_LOGSQ && alu_done)
            frac_reg <= {frac_reg[13:0], (sq_sh >= 64'h80000000)};
        if (state_reg == S_BONUS && alu_done)
            tmp_reg <= alu_res[55:8];
        if (state_next == S_IDLE && state_reg != S_IDLE && item_reg.last_child)
        begin
            if (unv_seen_reg || (state_reg == S_EMIT && part && item_reg.child_visits == '0))
            begin
                out_data_reg.selected_child <= unv_seen_reg ? unv_child_reg
                                                            : item_reg.child_index;
                out_data_reg.no_legal_child <= 1'b0;
            end
            else if (state_reg == S_CMP && (!have_best_reg || score_sat > best_score_reg))
            begin
                out_data_reg.selected_child <= item_reg.child_index;
                out_data_reg.no_legal_child <= 1'b0;
            end
            else
            begin
                out_data_reg.selected_child <= have_best_reg ? best_child_reg : '0;
                out_data_reg.no_legal_child <= !have_best_reg;
            end
        end
    end

    // A choice beat only follows a closing child
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(item_reg.last_child))
        else $error("choice beat without a last child");

    // A reported choice is never index zero unless no child was legal
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.no_legal_child || out_data.selected_child != '0))
        else $error("index zero selected");

    // No item is taken while a score is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !take)
        else $error("item taken while busy");

endmodule : ucb1_child_selector
`default_nettype wire
